### rtl/ffla_pkg.sv
// ffla_pkg: shared constants, codes and types of the handle pool allocator
// no dependencies; imported by ffla_store and fifo_free_list_allocator
`timescale 1ns / 1ps

package ffla_pkg;

   localparam int POOL_SIZE = 256;
   localparam int HANDLE_W  = 8;
   localparam int PTR_W     = $clog2(POOL_SIZE);
   localparam int COUNT_W   = PTR_W + 1;

   typedef enum logic [1:0] {
      OP_ALLOC     = 2'd0,
      OP_TRY_ALLOC = 2'd1,
      OP_RELEASE   = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NONE        = 2'd1,
      ST_BAD_RELEASE = 2'd2,
      ST_EXHAUSTED   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   // access controls for the bitmap and release queue memories
   typedef struct packed {
      logic             map_rd_en;
      logic [PTR_W-1:0] map_rd_addr;
      logic             map_wr_en;
      logic [PTR_W-1:0] map_wr_addr;
      logic             map_wr_data;
      logic             q_rd_en;
      logic [PTR_W-1:0] q_rd_addr;
      logic             q_wr_en;
      logic [PTR_W-1:0] q_wr_addr;
      logic [PTR_W-1:0] q_wr_data;
   } mem_ctl_type;

   // circular pointer advance
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(POOL_SIZE - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

endpackage

### rtl/fifo_free_list_allocator.sv
// fifo_free_list_allocator: handle pool with first-in first-out reuse of released handles
// depends on ffla_pkg and ffla_store
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// req       in         req_tvalid/req_tready  tuser: opcode[1:0]; tdata: handle_in[7:0]
// rsp       out        rsp_tvalid/rsp_tready  tuser: status[1:0]; tdata: handle_out[7:0]
//
// each request is accepted in S_IDLE, where the accepting edge launches the bitmap and queue
// reads; S_EXEC then decides, writes both memories back and loads the result register
// one result register on rsp; a new request is taken while a result still waits
// the decide step holds while the result register is full and not being taken
// after reset a clearing pass over all POOL_SIZE (256) bitmap entries zeroes the bitmap
// with req_tready low

module fifo_free_list_allocator
   import ffla_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // handle_in[7:0]
   input  logic [1:0]          req_tuser,   // opcode[1:0]

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [HANDLE_W-1:0] rsp_tdata,   // handle_out[7:0]
   output logic [1:0]          rsp_tuser    // status[1:0]
);

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    clear_idx_ff, clear_idx_in;

   // request captured at acceptance
   logic [1:0]          op_ff;
   logic [PTR_W-1:0]    hin_ff;

   // queue and fresh-handle bookkeeping
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  fresh_ff, fresh_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;

   mem_ctl_type         mem_ctl;
   logic                map_rd_data;
   logic [PTR_W-1:0]    q_rd_data;

   logic                accept;
   logic                rsp_free;
   logic                exec_done;
   logic                is_alloc;
   logic                queue_empty;
   logic                from_queue;
   logic                from_fresh;
   logic                release_ok;
   logic [PTR_W-1:0]    grant;
   logic [1:0]          status;

   ffla_store u_store (
      .clock       (clock),
      .mem_ctl     (mem_ctl),
      .map_rd_data (map_rd_data),
      .q_rd_data   (q_rd_data)
   );

   assign accept    = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign exec_done = (state_ff == S_EXEC) && rsp_free;

   // decision on the registered memory reads
   assign is_alloc    = (op_ff == OP_ALLOC) || (op_ff == OP_TRY_ALLOC);
   assign queue_empty = (count_ff == '0);
   assign from_queue  = is_alloc && !queue_empty;
   assign from_fresh  = (op_ff == OP_ALLOC) && queue_empty
                        && (fresh_ff < COUNT_W'(POOL_SIZE));
   // handle_in is never out of range with an 8-bit field and 256 handles
   assign release_ok  = (op_ff == OP_RELEASE) && map_rd_data
                        && (count_ff < COUNT_W'(POOL_SIZE));

   always_comb begin
      grant  = '0;
      status = ST_OK;
      if (from_queue) begin
         grant = q_rd_data;
      end else if (from_fresh) begin
         grant = fresh_ff[PTR_W-1:0];
      end else if (op_ff == OP_TRY_ALLOC) begin
         status = ST_NONE;
      end else if (op_ff == OP_ALLOC) begin
         status = ST_EXHAUSTED;
      end else if (op_ff == OP_RELEASE && !release_ok) begin
         status = ST_BAD_RELEASE;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_idx_ff == PTR_W'(POOL_SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs of the sequencer: handshake and memory controls
   always_comb begin
      req_tready          = 1'b0;
      mem_ctl             = '0;
      mem_ctl.map_rd_addr = req_tdata[PTR_W-1:0];
      mem_ctl.q_rd_addr   = head_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_ctl.map_wr_en   = 1'b1;
            mem_ctl.map_wr_addr = clear_idx_ff;
            mem_ctl.map_wr_data = 1'b0;
         end
         S_IDLE: begin
            // ready is high here, so a valid request is a transfer
            req_tready        = 1'b1;
            mem_ctl.map_rd_en = req_tvalid;
            mem_ctl.q_rd_en   = req_tvalid;
         end
         S_EXEC: begin
            if (rsp_free) begin
               if (from_queue || from_fresh) begin
                  mem_ctl.map_wr_en   = 1'b1;
                  mem_ctl.map_wr_addr = grant;
                  mem_ctl.map_wr_data = 1'b1;
               end else if (release_ok) begin
                  mem_ctl.map_wr_en   = 1'b1;
                  mem_ctl.map_wr_addr = hin_ff;
                  mem_ctl.map_wr_data = 1'b0;
                  mem_ctl.q_wr_en     = 1'b1;
                  mem_ctl.q_wr_addr   = tail_ff;
                  mem_ctl.q_wr_data   = hin_ff;
               end
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // bookkeeping and result register next values
   always_comb begin
      clear_idx_in  = clear_idx_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      if (state_ff == S_CLEAR) begin
         clear_idx_in = ptr_next(clear_idx_ff);
      end
      if (exec_done) begin
         rsp_valid_in  = 1'b1;
         rsp_handle_in = HANDLE_W'(grant);
         rsp_status_in = status;
         if (from_queue) begin
            head_in  = ptr_next(head_ff);
            count_in = count_ff - COUNT_W'(1);
         end else if (from_fresh) begin
            fresh_in = fresh_ff + COUNT_W'(1);
         end else if (release_ok) begin
            tail_in  = ptr_next(tail_ff);
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clear_idx_ff <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_tuser;
         hin_ff <= req_tdata[PTR_W-1:0];
      end
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_handle_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

### rtl/ffla_store.sv
// ffla_store: allocated bitmap and release queue memories
// one write and one registered read port each; depends on ffla_pkg
`timescale 1ns / 1ps

module ffla_store
   import ffla_pkg::*;
(
   input  logic             clock,
   input  mem_ctl_type      mem_ctl,
   output logic             map_rd_data,
   output logic [PTR_W-1:0] q_rd_data
);

   logic             map_mem [POOL_SIZE];
   logic [PTR_W-1:0] q_mem   [POOL_SIZE];
   logic             map_rd_ff;
   logic [PTR_W-1:0] q_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.map_wr_en) begin
         map_mem[mem_ctl.map_wr_addr] <= mem_ctl.map_wr_data;
      end
      if (mem_ctl.map_rd_en) begin
         map_rd_ff <= map_mem[mem_ctl.map_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.q_wr_en) begin
         q_mem[mem_ctl.q_wr_addr] <= mem_ctl.q_wr_data;
      end
      if (mem_ctl.q_rd_en) begin
         q_rd_ff <= q_mem[mem_ctl.q_rd_addr];
      end
   end

   assign map_rd_data = map_rd_ff;
   assign q_rd_data   = q_rd_ff;

endmodule

### sim/fifo_free_list_allocator_tb.sv
// fifo_free_list_allocator_tb: self-checking testbench of the handle pool allocator
// drives random and directed requests, predicts each grant and checks every response
// depends on ffla_pkg and fifo_free_list_allocator
`timescale 1ns / 1ps

module fifo_free_list_allocator_tb;
   import ffla_pkg::*;

   // opcode value the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // request mixes of the random part
   localparam int EP_FILL  = 0;
   localparam int EP_DRAIN = 1;
   localparam int EP_MIX   = 2;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SEGMENT_ITEMS    = 210;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // handle_in[7:0]
   logic [1:0]          req_tuser;   // opcode[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [HANDLE_W-1:0] rsp_tdata;   // handle_out[7:0]
   logic [1:0]          rsp_tuser;   // status[1:0]

   // idling controls of the sender and the receiver
   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_request;
   bit hold_taken;
   int hold_left;

   fifo_free_list_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // predicted pool state and the grants still owed by the block
   class grant_scoreboard;
      typedef struct {
         logic [HANDLE_W-1:0] handle;
         status_type          status;
      } grant_type;

      bit                  in_use [POOL_SIZE];
      logic [HANDLE_W-1:0] reuse_fifo [$];
      int unsigned         fresh_next;
      grant_type           owed [$];
      int                  errors;

      function new();
         foreach (in_use[i]) in_use[i] = 1'b0;
         fresh_next = 0;
         errors     = 0;
      endfunction

      // predict the grant of one accepted request and update the pool
      function void note_request(logic [1:0] op, logic [7:0] handle_in);
         grant_type g;
         g.handle = '0;
         g.status = ST_OK;
         if (op == OP_ALLOC || op == OP_TRY_ALLOC) begin
            if (reuse_fifo.size() > 0) begin
               // oldest released handle goes out first
               g.handle = reuse_fifo.pop_front();
               in_use[g.handle] = 1'b1;
            end else if (op == OP_TRY_ALLOC) begin
               g.status = ST_NONE;
            end else if (fresh_next < POOL_SIZE) begin
               g.handle = HANDLE_W'(fresh_next);
               in_use[fresh_next] = 1'b1;
               fresh_next++;
            end else begin
               g.status = ST_EXHAUSTED;
            end
         end else if (op == OP_RELEASE) begin
            if (int'(handle_in) < POOL_SIZE && in_use[handle_in]
                && reuse_fifo.size() < POOL_SIZE) begin
               in_use[handle_in] = 1'b0;
               reuse_fifo.push_back(handle_in);
            end else begin
               g.status = ST_BAD_RELEASE;
            end
         end
         owed.push_back(g);
      endfunction

      // random handle that is currently allocated, if there is one
      function bit pick_in_use(output logic [7:0] handle);
         int start;
         int idx;
         start  = $urandom_range(0, POOL_SIZE - 1);
         handle = '0;
         for (int i = 0; i < POOL_SIZE; i++) begin
            idx = (start + i) % POOL_SIZE;
            if (in_use[idx]) begin
               handle = 8'(idx);
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function bit pool_exhausted();
         return fresh_next >= POOL_SIZE && reuse_fifo.size() == 0;
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // compare one response transfer with the oldest owed grant
      task check_result(logic [HANDLE_W-1:0] handle_out, logic [1:0] status);
         grant_type g;
         if (owed.size() == 0) begin
            report_mismatch($sformatf("response with nothing owed: handle %0d status %0d",
                                      handle_out, status));
         end else begin
            g = owed.pop_front();
            if (handle_out !== g.handle) begin
               report_mismatch($sformatf("handle_out %0d, predicted %0d",
                                         handle_out, g.handle));
            end
            if (status !== g.status) begin
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         status, g.status));
            end
         end
      endtask
   endclass

   grant_scoreboard sb = new();

   // clock, period 4 ns
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // response side: random stalls plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_left  = LONG_HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = !($urandom_range(0, 99) < receiver_stall_pct);
         end
      end
   end

   // check every response transfer at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // offer one request and wait for its transfer; valid stays high afterwards
   task send_request(logic [1:0] op, logic [7:0] handle_in);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = handle_in;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(op, handle_in);
   endtask

   // drop valid after the last transfer of a run
   task go_quiet();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // hold off until every owed grant has come back
   task wait_drained();
      while (sb.owed.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // choose one random request according to the current mix
   task pick_request(int mix, output logic [1:0] op, output logic [7:0] handle_in);
      int r;
      int alloc_pct;
      int try_pct;
      int good_pct;
      int bad_pct;
      logic [7:0] h;
      case (mix)
         EP_FILL: begin
            alloc_pct = 80; try_pct = 8; good_pct = 8; bad_pct = 3;
         end
         EP_DRAIN: begin
            alloc_pct = 8; try_pct = 6; good_pct = 74; bad_pct = 10;
         end
         default: begin
            alloc_pct = 35; try_pct = 15; good_pct = 35; bad_pct = 12;
         end
      endcase
      r         = $urandom_range(0, 99);
      handle_in = 8'($urandom_range(0, 255));
      if (r < alloc_pct) begin
         op = OP_ALLOC;
      end else if (r < alloc_pct + try_pct) begin
         op = OP_TRY_ALLOC;
      end else if (r < alloc_pct + try_pct + good_pct) begin
         // release of a live handle; falls back to a stray one when none is live
         op = OP_RELEASE;
         if (sb.pick_in_use(h)) begin
            handle_in = h;
         end
      end else if (r < alloc_pct + try_pct + good_pct + bad_pct) begin
         op = OP_RELEASE;
      end else begin
         op = OP_UNUSED;
      end
   endtask

   // one segment of random episodes under one idling mode
   task random_segment(int idle_pct, int stall_pct, int count);
      int left;
      int run_len;
      int mix;
      logic [1:0] op;
      logic [7:0] h;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      left = count;
      while (left > 0) begin
         run_len = $urandom_range(10, 60);
         mix     = $urandom_range(EP_FILL, EP_MIX);
         for (int i = 0; i < run_len && left > 0; i++) begin
            pick_request(mix, op, h);
            send_request(op, h);
            left--;
         end
      end
   endtask

   // hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = OP_ALLOC;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty pool, stray and double releases, reuse order, ignored opcode
      send_request(OP_TRY_ALLOC, 8'h00);   // nothing queued yet
      send_request(OP_RELEASE,   8'h00);   // never allocated
      send_request(OP_RELEASE,   8'hFF);
      send_request(OP_UNUSED,    8'hFF);   // ignored, plain ok response
      send_request(OP_ALLOC,     8'hFF);   // fresh handles, handle_in ignored
      send_request(OP_ALLOC,     8'h00);
      send_request(OP_ALLOC,     8'h5A);
      send_request(OP_RELEASE,   8'h01);
      send_request(OP_RELEASE,   8'h01);   // double release
      send_request(OP_TRY_ALLOC, 8'hA5);   // reuses the released one
      send_request(OP_TRY_ALLOC, 8'h00);   // queue empty again
      send_request(OP_RELEASE,   8'h02);
      send_request(OP_RELEASE,   8'h00);
      send_request(OP_ALLOC,     8'h00);   // oldest release first
      send_request(OP_ALLOC,     8'h00);
      send_request(OP_ALLOC,     8'h00);   // back to fresh handles
      send_request(OP_RELEASE,   8'hAA);
      send_request(OP_UNUSED,    8'h55);
      send_request(OP_RELEASE,   8'h03);
      send_request(OP_RELEASE,   8'h03);
      go_quiet();
      wait_drained();

      // run the pool dry while the receiver holds off, so the input backs up
      hold_request = 1'b1;
      while (!sb.pool_exhausted()) begin
         send_request(OP_ALLOC, 8'($urandom_range(0, 255)));
      end
      send_request(OP_ALLOC,     8'h00);   // exhausted
      send_request(OP_ALLOC,     8'hFF);
      send_request(OP_TRY_ALLOC, 8'h00);   // none free
      go_quiet();
      wait_drained();

      // random part under each idling mode, with a full pause between segments
      random_segment(0, 0, SEGMENT_ITEMS);
      go_quiet();
      wait_drained();
      random_segment(73, 0, SEGMENT_ITEMS);
      go_quiet();
      wait_drained();
      random_segment(0, 73, SEGMENT_ITEMS);
      go_quiet();
      wait_drained();
      random_segment(6, 6, SEGMENT_ITEMS);
      go_quiet();

      // let the last responses out and catch any stray ones
      receiver_stall_pct = 0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.owed.size() != 0) begin
         sb.report_mismatch($sformatf("%0d grants never came back", sb.owed.size()));
      end
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
